// File: hw/rtl/ierf_pkg.sv
// ierf_pkg: shared types and constants for the ipv4 echo reply filter
// used by ipv4_echo_reply_filter and ierf_checker; no dependencies

package ierf_pkg;

  typedef enum logic [3:0] {
    VERDICT_ACCEPTED     = 4'd0,
    VERDICT_TOO_SHORT    = 4'd1,
    VERDICT_BAD_VERSION  = 4'd2,
    VERDICT_HDR_LENGTH   = 4'd3,
    VERDICT_TOTAL_LENGTH = 4'd4,
    VERDICT_CHECKSUM     = 4'd5,
    VERDICT_FRAGMENT     = 4'd6,
    VERDICT_NO_INTERFACE = 4'd7,
    VERDICT_NOT_FOR_US   = 4'd8,
    VERDICT_NOT_REPLY    = 4'd9,
    VERDICT_ID_MISMATCH  = 4'd10,
    VERDICT_REPLY_SHORT  = 4'd11
  } verdict_t;

  typedef enum logic [1:0] {
    REG_INTERFACE_PRESENT = 2'd0,
    REG_UNICAST_ADDR      = 2'd1,
    REG_BROADCAST_ADDR    = 2'd2,
    REG_ECHO_ID           = 2'd3
  } reg_index_t;

  typedef struct packed {
    verdict_t     verdict;
    logic [31:0]  source_addr;
    logic [7:0]   time_to_live;
    logic [15:0]  echo_sequence;
    logic [15:0]  packet_length;
  } result_t;

  localparam logic        RST_INTERFACE_PRESENT = 1'b1;
  localparam logic [31:0] RST_UNICAST_ADDR      = 32'h7F00_0001;
  localparam logic [31:0] RST_BROADCAST_ADDR    = 32'h7FFF_FFFF;
  localparam logic [15:0] RST_ECHO_ID           = 16'h0000;

  localparam logic [31:0] ALL_ONES_ADDR   = 32'hFFFF_FFFF;
  localparam logic [3:0]  IHL_MASK        = 4'h0f;
  localparam logic [15:0] MF_FLAG         = 16'h2000;
  localparam logic [15:0] FRAG_OFS_MASK   = 16'h1fff;
  localparam logic [15:0] CSUM_GOOD       = 16'hFFFF;
  localparam logic [15:0] COUNT_LIMIT     = 16'hFFFF;
  localparam logic [15:0] MIN_IP_BYTES    = 16'd20;
  localparam logic [16:0] ECHO_HDR_BYTES  = 17'd8;
  localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
  localparam logic [3:0]  IP_VERSION_4    = 4'd4;

endpackage

// File: hw/rtl/ipv4_echo_reply_filter.sv
// ipv4_echo_reply_filter: byte-serial ipv4 header check and icmp echo reply filter
// depends on ierf_pkg

// Takes one packet byte per cycle on the input channel while in_stall is low and
// gives one registered verdict word for the byte marked last_byte, with the source
// address, ttl, echo sequence number and saturating byte count of that packet.
// Each byte only updates a set of running header registers; the verdict is
// formed from them in the same cycle and lands in an output register backed by
// a one-word skid stage. in_stall is high only while that skid stage is full,
// which happens after a verdict met out_stall; otherwise a byte is taken every
// cycle. Configuration goes through the apb port, registers at 4-byte spacing.
module ipv4_echo_reply_filter (
  input  logic        clk,
  input  logic        rst,
  // packet bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // verdicts
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  verdict,
  output logic [31:0] source_addr,
  output logic [7:0]  time_to_live,
  output logic [15:0] echo_sequence,
  output logic [15:0] packet_length,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ierf_pkg::*;

  localparam logic [15:0] OFS_TOTLEN_HI = 16'd2;
  localparam logic [15:0] OFS_TOTLEN_LO = 16'd3;
  localparam logic [15:0] OFS_FRAG_HI   = 16'd6;
  localparam logic [15:0] OFS_FRAG_LO   = 16'd7;
  localparam logic [15:0] OFS_TTL       = 16'd8;
  localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
  localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
  localparam logic [15:0] OFS_DST_FIRST = 16'd16;
  localparam logic [15:0] OFS_DST_LAST  = 16'd19;

  // configuration registers
  logic        interface_present;
  logic [31:0] unicast_addr;
  logic [31:0] broadcast_addr;
  logic [15:0] echo_id;

  // per-packet state
  logic [15:0] byte_count,      byte_count_next,      byte_count_upd;
  logic [5:0]  header_length,   header_length_next,   header_length_upd;
  logic [3:0]  version_field,   version_field_next,   version_field_upd;
  logic [15:0] total_length,    total_length_next,    total_length_upd;
  logic [16:0] checksum_accum,  checksum_accum_next,  checksum_accum_upd;
  logic [7:0]  high_byte_hold,  high_byte_hold_next,  high_byte_hold_upd;
  logic [15:0] fragment_bits,   fragment_bits_next,   fragment_bits_upd;
  logic [7:0]  ttl_hold,        ttl_hold_next,        ttl_hold_upd;
  logic [31:0] source_hold,     source_hold_next,     source_hold_upd;
  logic [31:0] dest_hold,       dest_hold_next,       dest_hold_upd;
  logic [7:0]  icmp_type_hold,  icmp_type_hold_next,  icmp_type_hold_upd;
  logic [31:0] id_and_seq_hold, id_and_seq_hold_next, id_and_seq_hold_upd;

  logic        in_accept;
  logic        new_result;
  logic [17:0] csum_sum;
  logic [15:0] rel;
  verdict_t    verdict_now;
  result_t     result_now;

  // output register and skid stage
  logic        skid_valid;
  result_t     out_word;
  result_t     skid_word;
  logic        out_free;

  // apb configuration port
  logic        cfg_write;
  reg_index_t  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      interface_present <= RST_INTERFACE_PRESENT;
      unicast_addr      <= RST_UNICAST_ADDR;
      broadcast_addr    <= RST_BROADCAST_ADDR;
      echo_id           <= RST_ECHO_ID;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INTERFACE_PRESENT: interface_present <= pwdata[0];
        REG_UNICAST_ADDR:      unicast_addr      <= pwdata;
        REG_BROADCAST_ADDR:    broadcast_addr    <= pwdata;
        REG_ECHO_ID:           echo_id           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_INTERFACE_PRESENT: prdata = {31'd0, interface_present};
      REG_UNICAST_ADDR:      prdata = unicast_addr;
      REG_BROADCAST_ADDR:    prdata = broadcast_addr;
      REG_ECHO_ID:           prdata = {16'd0, echo_id};
      default:               prdata = 32'd0;
    endcase
  end

  assign in_stall   = skid_valid;
  assign in_accept  = in_valid && !in_stall;
  assign new_result = in_accept && last_byte;

  // running header state after the current byte
  always_comb begin
    header_length_upd   = header_length;
    version_field_upd   = version_field;
    total_length_upd    = total_length;
    checksum_accum_upd  = checksum_accum;
    high_byte_hold_upd  = high_byte_hold;
    fragment_bits_upd   = fragment_bits;
    ttl_hold_upd        = ttl_hold;
    source_hold_upd     = source_hold;
    dest_hold_upd       = dest_hold;
    icmp_type_hold_upd  = icmp_type_hold;
    id_and_seq_hold_upd = id_and_seq_hold;

    if (byte_count == 16'd0) begin
      header_length_upd = {data_byte[3:0] & IHL_MASK, 2'b00};
      version_field_upd = data_byte[7:4];
    end

    if (byte_count == OFS_TOTLEN_HI) total_length_upd[15:8] = data_byte;
    if (byte_count == OFS_TOTLEN_LO) total_length_upd[7:0]  = data_byte;
    if (byte_count == OFS_FRAG_HI)   fragment_bits_upd[15:8] = data_byte;
    if (byte_count == OFS_FRAG_LO)   fragment_bits_upd[7:0]  = data_byte;
    if (byte_count == OFS_TTL)       ttl_hold_upd = data_byte;
    if (byte_count >= OFS_SRC_FIRST && byte_count <= OFS_SRC_LAST) begin
      source_hold_upd = {source_hold[23:0], data_byte};
    end
    if (byte_count >= OFS_DST_FIRST && byte_count <= OFS_DST_LAST) begin
      dest_hold_upd = {dest_hold[23:0], data_byte};
    end

    csum_sum = {1'b0, checksum_accum} + {2'b00, high_byte_hold, data_byte};
    rel      = byte_count - {10'd0, header_length_upd};

    if (byte_count < {10'd0, header_length_upd}) begin
      if (!byte_count[0]) begin
        high_byte_hold_upd = data_byte;
      end else begin
        checksum_accum_upd = {1'b0, csum_sum[15:0]} + {15'd0, csum_sum[17:16]};
      end
    end else begin
      if (rel == 16'd0) begin
        icmp_type_hold_upd = data_byte;
      end else if (rel inside {[16'd4:16'd7]}) begin
        id_and_seq_hold_upd = {id_and_seq_hold[23:0], data_byte};
      end
    end

    if (byte_count != COUNT_LIMIT) begin
      byte_count_upd = byte_count + 16'd1;
    end else begin
      byte_count_upd = byte_count;
    end
  end

  // verdict from the updated state
  always_comb begin
    if (byte_count_upd < MIN_IP_BYTES) begin
      verdict_now = VERDICT_TOO_SHORT;
    end else if (version_field_upd != IP_VERSION_4) begin
      verdict_now = VERDICT_BAD_VERSION;
    end else if (byte_count_upd < {10'd0, header_length_upd}) begin
      verdict_now = VERDICT_HDR_LENGTH;
    end else if (byte_count_upd < total_length_upd) begin
      verdict_now = VERDICT_TOTAL_LENGTH;
    end else if (checksum_accum_upd != {1'b0, CSUM_GOOD}) begin
      verdict_now = VERDICT_CHECKSUM;
    end else if ((fragment_bits_upd & (MF_FLAG | FRAG_OFS_MASK)) != 16'd0) begin
      verdict_now = VERDICT_FRAGMENT;
    end else if (!interface_present) begin
      verdict_now = VERDICT_NO_INTERFACE;
    end else if (dest_hold_upd != unicast_addr && dest_hold_upd != broadcast_addr &&
                 dest_hold_upd != ALL_ONES_ADDR) begin
      verdict_now = VERDICT_NOT_FOR_US;
    end else if (icmp_type_hold_upd != ICMP_ECHO_REPLY) begin
      verdict_now = VERDICT_NOT_REPLY;
    end else if (id_and_seq_hold_upd[31:16] != echo_id) begin
      verdict_now = VERDICT_ID_MISMATCH;
    end else if ({1'b0, byte_count_upd} < 17'(header_length_upd) + ECHO_HDR_BYTES) begin
      verdict_now = VERDICT_REPLY_SHORT;
    end else begin
      verdict_now = VERDICT_ACCEPTED;
    end

    result_now.verdict       = verdict_now;
    result_now.source_addr   = source_hold_upd;
    result_now.time_to_live  = ttl_hold_upd;
    result_now.echo_sequence = id_and_seq_hold_upd[15:0];
    result_now.packet_length = byte_count_upd;
  end

  // state update, cleared after each verdict
  always_comb begin
    byte_count_next      = byte_count;
    header_length_next   = header_length;
    version_field_next   = version_field;
    total_length_next    = total_length;
    checksum_accum_next  = checksum_accum;
    high_byte_hold_next  = high_byte_hold;
    fragment_bits_next   = fragment_bits;
    ttl_hold_next        = ttl_hold;
    source_hold_next     = source_hold;
    dest_hold_next       = dest_hold;
    icmp_type_hold_next  = icmp_type_hold;
    id_and_seq_hold_next = id_and_seq_hold;
    if (in_accept && last_byte) begin
      byte_count_next      = '0;
      header_length_next   = '0;
      version_field_next   = '0;
      total_length_next    = '0;
      checksum_accum_next  = '0;
      high_byte_hold_next  = '0;
      fragment_bits_next   = '0;
      ttl_hold_next        = '0;
      source_hold_next     = '0;
      dest_hold_next       = '0;
      icmp_type_hold_next  = '0;
      id_and_seq_hold_next = '0;
    end else if (in_accept) begin
      byte_count_next      = byte_count_upd;
      header_length_next   = header_length_upd;
      version_field_next   = version_field_upd;
      total_length_next    = total_length_upd;
      checksum_accum_next  = checksum_accum_upd;
      high_byte_hold_next  = high_byte_hold_upd;
      fragment_bits_next   = fragment_bits_upd;
      ttl_hold_next        = ttl_hold_upd;
      source_hold_next     = source_hold_upd;
      dest_hold_next       = dest_hold_upd;
      icmp_type_hold_next  = icmp_type_hold_upd;
      id_and_seq_hold_next = id_and_seq_hold_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      header_length   <= '0;
      version_field   <= '0;
      total_length    <= '0;
      checksum_accum  <= '0;
      high_byte_hold  <= '0;
      fragment_bits   <= '0;
      ttl_hold        <= '0;
      source_hold     <= '0;
      dest_hold       <= '0;
      icmp_type_hold  <= '0;
      id_and_seq_hold <= '0;
    end else begin
      byte_count      <= byte_count_next;
      header_length   <= header_length_next;
      version_field   <= version_field_next;
      total_length    <= total_length_next;
      checksum_accum  <= checksum_accum_next;
      high_byte_hold  <= high_byte_hold_next;
      fragment_bits   <= fragment_bits_next;
      ttl_hold        <= ttl_hold_next;
      source_hold     <= source_hold_next;
      dest_hold       <= dest_hold_next;
      icmp_type_hold  <= icmp_type_hold_next;
      id_and_seq_hold <= id_and_seq_hold_next;
    end
  end

  // output register with skid stage
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || new_result;
      skid_valid <= 1'b0;
    end else if (new_result) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (new_result) begin
        out_word <= result_now;
      end
    end else if (new_result) begin
      skid_word <= result_now;
    end
  end

  assign verdict       = out_word.verdict;
  assign source_addr   = out_word.source_addr;
  assign time_to_live  = out_word.time_to_live;
  assign echo_sequence = out_word.echo_sequence;
  assign packet_length = out_word.packet_length;

endmodule

// File: hw/rtl/ierf_checker.sv
// ierf_checker: port-level assertions for ipv4_echo_reply_filter, bound to the top level
// depends on ierf_pkg and ipv4_echo_reply_filter

module ierf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  verdict,
  input logic [15:0] packet_length
);
  import ierf_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(packet_length))
    else $error("stalled output word changed");

  // a last byte is always followed by out_valid on the next cycle
  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("no word after last byte");

  // input backpressure only follows output backpressure
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output stall");

  // too short exactly when fewer than twenty bytes
  a_short_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((verdict == VERDICT_TOO_SHORT) == (packet_length < MIN_IP_BYTES)))
    else $error("too-short verdict disagrees with length");

  // an accepted reply is never shorter than a minimal header
  a_accept_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_ACCEPTED |-> packet_length >= MIN_IP_BYTES)
    else $error("accepted reply too short");

endmodule

bind ipv4_echo_reply_filter ierf_checker u_ierf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .last_byte     (last_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .verdict       (verdict),
  .packet_length (packet_length)
);

// File: tb/ipv4_echo_reply_filter_tb.sv
// ipv4_echo_reply_filter_tb: self-checking testbench for the byte-serial ipv4 echo reply filter
// drives packets as byte words, predicts each verdict word and compares it field by field
// depends on ierf_pkg and ipv4_echo_reply_filter

module ipv4_echo_reply_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ierf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  verdict;
  logic [31:0] source_addr;
  logic [7:0]  time_to_live;
  logic [15:0] echo_sequence;
  logic [15:0] packet_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  ipv4_echo_reply_filter u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .verdict(verdict),
    .source_addr(source_addr), .time_to_live(time_to_live),
    .echo_sequence(echo_sequence), .packet_length(packet_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // filter configuration as the predictor sees it
  logic        cfg_iface   = RST_INTERFACE_PRESENT;
  logic [31:0] cfg_unicast = RST_UNICAST_ADDR;
  logic [31:0] cfg_bcast   = RST_BROADCAST_ADDR;
  logic [15:0] cfg_echo_id = RST_ECHO_ID;

  // running header state of the packet in flight
  logic [15:0] rx_count   = '0;
  logic [5:0]  hdr_len    = '0;
  logic [3:0]  ip_ver     = '0;
  logic [15:0] tot_len    = '0;
  logic [16:0] csum       = '0;
  logic [7:0]  hi_hold    = '0;
  logic [15:0] frag       = '0;
  logic [7:0]  ttl        = '0;
  logic [31:0] src        = '0;
  logic [31:0] dst        = '0;
  logic [7:0]  icmp_type  = '0;
  logic [31:0] id_seq     = '0;

  pkt_word_t   pending_words[$];
  result_t     expected_verdicts[$];
  logic [7:0]  frame[$];
  pkt_word_t   next_word;
  result_t     want;

  int          mismatches = 0;
  int          verdicts_checked = 0;
  int          packets_sent = 0;
  int          words_sent = 0;
  int          stalled_cycles = 0;
  int          settings = 1;
  logic [15:0] codes_seen = '0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  task automatic track_byte(input logic [7:0] b, input logic last);
    logic [15:0] idx;
    logic [5:0]  hl;
    logic [15:0] rel;
    result_t     r;
    idx = rx_count;
    if (idx == 16'd0) begin
      hl = {b[3:0], 2'b00};
      ip_ver = b[7:4];
      hdr_len = hl;
    end else begin
      hl = hdr_len;
    end
    case (idx)
      16'd2: tot_len[15:8] = b;
      16'd3: tot_len[7:0] = b;
      16'd6: frag[15:8] = b;
      16'd7: frag[7:0] = b;
      16'd8: ttl = b;
      16'd12, 16'd13, 16'd14, 16'd15: src = {src[23:0], b};
      16'd16, 16'd17, 16'd18, 16'd19: dst = {dst[23:0], b};
      default: ;
    endcase
    if (idx < {10'd0, hl}) begin
      if (!idx[0]) begin
        hi_hold = b;
      end else begin
        csum = csum + {1'b0, hi_hold, b};
        csum = {1'b0, csum[15:0]} + {16'd0, csum[16]};
      end
    end else begin
      rel = idx - {10'd0, hl};
      if (rel == 16'd0) icmp_type = b;
      else if (rel >= 16'd4 && rel <= 16'd7) id_seq = {id_seq[23:0], b};
    end
    if (idx != COUNT_LIMIT) rx_count = idx + 16'd1;
    if (last) begin
      if (rx_count < MIN_IP_BYTES) r.verdict = VERDICT_TOO_SHORT;
      else if (ip_ver != IP_VERSION_4) r.verdict = VERDICT_BAD_VERSION;
      else if (rx_count < {10'd0, hdr_len}) r.verdict = VERDICT_HDR_LENGTH;
      else if (rx_count < tot_len) r.verdict = VERDICT_TOTAL_LENGTH;
      else if (csum != {1'b0, CSUM_GOOD}) r.verdict = VERDICT_CHECKSUM;
      else if ((frag & (MF_FLAG | FRAG_OFS_MASK)) != 16'd0) r.verdict = VERDICT_FRAGMENT;
      else if (!cfg_iface) r.verdict = VERDICT_NO_INTERFACE;
      else if (dst != cfg_unicast && dst != cfg_bcast && dst != ALL_ONES_ADDR)
        r.verdict = VERDICT_NOT_FOR_US;
      else if (icmp_type != ICMP_ECHO_REPLY) r.verdict = VERDICT_NOT_REPLY;
      else if (id_seq[31:16] != cfg_echo_id) r.verdict = VERDICT_ID_MISMATCH;
      else if ({1'b0, rx_count} < {11'd0, hdr_len} + ECHO_HDR_BYTES)
        r.verdict = VERDICT_REPLY_SHORT;
      else r.verdict = VERDICT_ACCEPTED;
      r.source_addr = src;
      r.time_to_live = ttl;
      r.echo_sequence = id_seq[15:0];
      r.packet_length = rx_count;
      expected_verdicts.push_back(r);
      rx_count = '0;
      hdr_len = '0;
      ip_ver = '0;
      tot_len = '0;
      csum = '0;
      hi_hold = '0;
      frag = '0;
      ttl = '0;
      src = '0;
      dst = '0;
      icmp_type = '0;
      id_seq = '0;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // byte word driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() != 0 &&
          ((words_sent >= 300 && words_sent < 500) || $urandom_range(99) >= 17)) begin
        next_word = pending_words.pop_front();
        in_valid <= 1'b1;
        data_byte <= next_word.data;
        last_byte <= next_word.last;
        words_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // verdict receiver stall, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && verdicts_checked >= 5) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(verdicts_checked >= 10 && verdicts_checked < 18) &&
                   ($urandom_range(99) < 17);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) stalled_cycles++;
      if (in_valid && !in_stall) track_byte(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict word %0d arrived with none expected", verdict);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("verdict", 32'(want.verdict), 32'(verdict));
          check_field("source_addr", want.source_addr, source_addr);
          check_field("time_to_live", 32'(want.time_to_live), 32'(time_to_live));
          check_field("echo_sequence", 32'(want.echo_sequence), 32'(echo_sequence));
          check_field("packet_length", 32'(want.packet_length), 32'(packet_length));
          codes_seen[want.verdict] = 1'b1;
          verdicts_checked++;
        end
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_INTERFACE_PRESENT: cfg_iface = value[0];
      REG_UNICAST_ADDR:      cfg_unicast = value;
      REG_BROADCAST_ADDR:    cfg_bcast = value;
      REG_ECHO_ID:           cfg_echo_id = value[15:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // header checksum over the bytes present, field at offsets 10 and 11
  task automatic set_checksum();
    logic [16:0] acc;
    int          hl;
    hl = frame[0][3:0] * 4;
    acc = '0;
    if (hl > 11) begin
      frame[10] = 8'd0;
      frame[11] = 8'd0;
    end
    for (int k = 0; k + 1 < hl && k + 1 < frame.size(); k += 2) begin
      acc = acc + {1'b0, frame[k], frame[k + 1]};
      acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
    end
    if (hl > 11) begin
      frame[10] = ~acc[15:8];
      frame[11] = ~acc[7:0];
    end
  endtask

  task automatic build_reply(input int ihl, input int payload, input logic [31:0] dest,
                             input logic [15:0] ident, input logic [7:0] kind);
    int tot;
    tot = ihl * 4 + 8 + payload;
    frame.delete();
    frame.push_back({4'd4, ihl[3:0]});
    frame.push_back(8'($urandom_range(255)));
    frame.push_back(tot[15:8]);
    frame.push_back(tot[7:0]);
    frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'($urandom_range(255)));
    frame.push_back($urandom_range(1) ? 8'h40 : 8'h00);
    frame.push_back(8'h00);
    frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'd1);
    frame.push_back(8'd0);
    frame.push_back(8'd0);
    for (int k = 0; k < 4; k++) frame.push_back(8'($urandom_range(255)));
    for (int k = 3; k >= 0; k--) frame.push_back(dest[8*k +: 8]);
    for (int k = 20; k < ihl * 4; k++) frame.push_back(8'($urandom_range(255)));
    frame.push_back(kind);
    for (int k = 0; k < 3; k++) frame.push_back(8'($urandom_range(255)));
    frame.push_back(ident[15:8]);
    frame.push_back(ident[7:0]);
    for (int k = 0; k < 2 + payload; k++) frame.push_back(8'($urandom_range(255)));
    set_checksum();
  endtask

  task automatic set_length(input int n);
    frame[2] = n[15:8];
    frame[3] = n[7:0];
    frame = frame[0:n-1];
    set_checksum();
  endtask

  task automatic queue_frame();
    for (int k = 0; k < frame.size(); k++)
      pending_words.push_back('{data: frame[k], last: (k == frame.size() - 1)});
    packets_sent++;
  endtask

  task automatic random_packet();
    int          pick;
    int          ihl;
    int          payload;
    int          r;
    logic [31:0] dest;
    logic [15:0] ident;
    pick = $urandom_range(99);
    if (pick < 8) begin
      frame.delete();
      repeat ($urandom_range(1, 70)) frame.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) frame[0] = 8'h45;
    end else begin
      ihl = ($urandom_range(99) < 80) ? 5 : $urandom_range(6, 15);
      payload = ($urandom_range(99) < 90) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      r = $urandom_range(99);
      dest = (r < 40) ? cfg_unicast : (r < 60) ? cfg_bcast : (r < 75) ? ALL_ONES_ADDR :
             32'($urandom);
      ident = ($urandom_range(99) < 85) ? cfg_echo_id : 16'($urandom);
      build_reply(ihl, payload, dest, ident,
                  ($urandom_range(99) < 90) ? ICMP_ECHO_REPLY : 8'($urandom_range(255)));
      if (pick >= 60) begin
        case ($urandom_range(7))
          0: frame[0][7:4] = 4'($urandom_range(15));
          1: frame[$urandom_range(ihl * 4 - 1)] ^= (8'd1 << $urandom_range(7));
          2: begin
            frame[6][5] = 1'b1;
            set_checksum();
          end
          3: begin
            frame[6][4:0] = 5'($urandom_range(31));
            frame[7] = 8'($urandom_range(255));
            set_checksum();
          end
          4: frame = frame[0:$urandom_range(20, frame.size() - 2)];
          5: set_length(ihl * 4 + $urandom_range(0, 7));
          6: repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom_range(255)));
          default: frame = frame[0:$urandom_range(0, 18)];
        endcase
      end
    end
    queue_frame();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one packet per check, then the odd header shapes
    build_reply(5, 0, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    queue_frame();
    build_reply(15, 40, RST_BROADCAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    queue_frame();
    build_reply(5, 8, ALL_ONES_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    queue_frame();
    frame.delete();
    frame.push_back(8'hFF);
    queue_frame();
    build_reply(5, 0, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame = frame[0:18];
    queue_frame();
    build_reply(5, 4, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame[0][7:4] = 4'hF;
    queue_frame();
    build_reply(15, 0, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame = frame[0:58];
    queue_frame();
    build_reply(5, 10, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame = frame[0:29];
    queue_frame();
    build_reply(5, 2, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame[11] ^= 8'h01;
    queue_frame();
    build_reply(5, 2, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame[6][5] = 1'b1;
    set_checksum();
    queue_frame();
    build_reply(5, 2, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame[6][4:0] = 5'h1F;
    frame[7] = 8'hFF;
    set_checksum();
    queue_frame();
    build_reply(5, 2, 32'h0A00_0001, 16'h0000, ICMP_ECHO_REPLY);
    queue_frame();
    build_reply(5, 2, RST_UNICAST_ADDR, 16'h0000, 8'd8);
    queue_frame();
    build_reply(5, 2, RST_UNICAST_ADDR, 16'hFFFF, ICMP_ECHO_REPLY);
    queue_frame();
    build_reply(5, 0, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    set_length(27);
    queue_frame();
    // ihl zero: empty header sum, icmp type taken from byte 0
    build_reply(5, 0, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame[0] = 8'h40;
    queue_frame();
    // ihl four: icmp part overlaps the destination address
    build_reply(5, 0, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame[0] = 8'h44;
    set_checksum();
    queue_frame();
    build_reply(5, 6, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    repeat (12) frame.push_back(8'hFF);
    queue_frame();

    wait_idle();
    write_reg(REG_INTERFACE_PRESENT, 32'd0);
    settings++;
    build_reply(5, 4, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    queue_frame();
    build_reply(5, 4, RST_UNICAST_ADDR, 16'h0000, ICMP_ECHO_REPLY);
    frame[0][7:4] = 4'h0;
    queue_frame();

    wait_idle();
    write_reg(REG_INTERFACE_PRESENT, 32'd1);
    write_reg(REG_UNICAST_ADDR, 32'h0000_0000);
    write_reg(REG_BROADCAST_ADDR, 32'hFFFF_FFFF);
    write_reg(REG_ECHO_ID, 32'h0000_FFFF);
    settings++;
    build_reply(5, 3, 32'h0000_0000, 16'hFFFF, ICMP_ECHO_REPLY);
    queue_frame();
    build_reply(5, 3, 32'hFFFF_FFFF, 16'hFFFF, ICMP_ECHO_REPLY);
    queue_frame();
    build_reply(5, 3, 32'h0000_0000, 16'h0000, ICMP_ECHO_REPLY);
    queue_frame();

    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      write_reg(REG_INTERFACE_PRESENT, (ph == 0 || $urandom_range(7) != 0) ? 32'd1 : 32'd0);
      write_reg(REG_UNICAST_ADDR, $urandom);
      write_reg(REG_BROADCAST_ADDR, $urandom);
      write_reg(REG_ECHO_ID, $urandom_range(16'hFFFF));
      settings++;
      repeat (3) random_packet();
    end

    wait_idle();
    $display("covered %0d packets (%0d byte words) over %0d register settings",
             packets_sent, words_sent, settings);
    $display("checked %0d verdicts, codes seen %b, input stalled %0d cycles",
             verdicts_checked, codes_seen[11:0], stalled_cycles);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d verdicts outstanding", expected_verdicts.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
